// File: hdl/mvote_pkg.sv
// ----------------------------------------------------------------------------
// mvote_pkg
// Shared types and codes for the mode vote block with early stop.
// ----------------------------------------------------------------------------
package mvote_pkg;

    localparam int unsigned NUM_ANSWERS = 4;
    localparam int unsigned CNT_W       = 8;
    localparam int unsigned TICK_W      = 16;
    localparam int unsigned ANS_W       = 3;
    localparam int unsigned PCT_W       = 7;
    localparam int unsigned PROD_W      = 15;
    localparam int unsigned CFG_IDX_W   = 8;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned S_DATA_W    = 8;
    localparam int unsigned M_DATA_W    = 24;

    // end causes
    localparam logic [1:0] CAUSE_EARLY   = 2'd0;
    localparam logic [1:0] CAUSE_MAX     = 2'd1;
    localparam logic [1:0] CAUSE_TIMEOUT = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_VOTES   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_VOTES   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DOM_PERCENT = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT     = 8'd3;

    // reset values
    localparam logic [CNT_W-1:0]  RST_MIN_VOTES   = 8'd20;
    localparam logic [CNT_W-1:0]  RST_MAX_VOTES   = 8'd100;
    localparam logic [PCT_W-1:0]  RST_DOM_PERCENT = 7'd30;
    localparam logic [TICK_W-1:0] RST_TIMEOUT     = 16'd5000;

    typedef logic [NUM_ANSWERS-1:0][CNT_W-1:0] t_counts;

    typedef struct packed {
        logic [CNT_W-1:0]  min_votes;
        logic [CNT_W-1:0]  max_votes;
        logic [PCT_W-1:0]  dominance_percent;
        logic [TICK_W-1:0] timeout_ticks;
    } t_cfg;

    typedef struct packed {
        t_counts           counts;
        logic [CNT_W-1:0]  votes;
        logic [TICK_W-1:0] ticks;
    } t_run;

    typedef struct packed {
        logic              valid_res;
        logic [ANS_W-1:0]  mode_value;
        logic [CNT_W-1:0]  mode_count;
        logic [CNT_W-1:0]  vote_count;
        logic [1:0]        end_cause;
    } t_result;

endpackage

// File: hdl/mvote_eval.sv
// ----------------------------------------------------------------------------
// mvote_eval
// Next run state and optional report for one vote or tick transaction.
// ----------------------------------------------------------------------------
module mvote_eval (
    input  mvote_pkg::t_cfg    i_cfg,
    input  mvote_pkg::t_run    i_run,
    input  logic               i_tick,
    input  logic [2:0]         i_answer,
    output mvote_pkg::t_run    o_next,
    output logic               o_emit,
    output mvote_pkg::t_result o_res
);
    import mvote_pkg::*;

    always_comb begin
        t_counts           counts_n;
        logic [CNT_W-1:0]  votes_n;
        logic [TICK_W-1:0] ticks_n;
        logic [ANS_W-1:0]  best_val;
        logic [CNT_W-1:0]  best_cnt;
        logic [ANS_W-1:0]  ans_m1;
        logic              ans_ok;
        logic [PROD_W-1:0] lhs;
        logic [PROD_W-1:0] rhs;
        logic              emit;
        logic [1:0]        cause;

        counts_n = i_run.counts;
        votes_n  = i_run.votes;
        ticks_n  = i_run.ticks;
        emit     = 1'b0;
        cause    = CAUSE_EARLY;
        ans_ok   = (i_answer != 3'd0) && (i_answer <= 3'd4);
        ans_m1   = i_answer - 3'd1;

        if (!i_tick && ans_ok) begin
            counts_n[ans_m1[1:0]] = i_run.counts[ans_m1[1:0]] + 8'd1;
            votes_n = i_run.votes + 8'd1;
        end
        if (i_tick && (i_run.ticks != 16'hFFFF)) begin
            ticks_n = i_run.ticks + 16'd1;
        end

        // strict compare: the smaller answer wins a tie
        best_val = '0;
        best_cnt = '0;
        for (int i = 0; i < NUM_ANSWERS; i++) begin
            if (counts_n[i] > best_cnt) begin
                best_cnt = counts_n[i];
                best_val = ANS_W'(i + 1);
            end
        end

        lhs = PROD_W'(best_cnt) * PROD_W'(100);
        rhs = PROD_W'(i_cfg.dominance_percent) * PROD_W'(votes_n);

        if (i_tick) begin
            if (ticks_n >= i_cfg.timeout_ticks) begin
                emit  = 1'b1;
                cause = CAUSE_TIMEOUT;
            end
        end else if (ans_ok) begin
            if ((votes_n >= i_cfg.min_votes) && (lhs > rhs)) begin
                emit  = 1'b1;
                cause = CAUSE_EARLY;
            end else if (votes_n >= i_cfg.max_votes) begin
                emit  = 1'b1;
                cause = CAUSE_MAX;
            end
        end

        o_emit           = emit;
        o_res.valid_res  = (votes_n >= i_cfg.min_votes);
        o_res.mode_value = best_val;
        o_res.mode_count = best_cnt;
        o_res.vote_count = votes_n;
        o_res.end_cause  = cause;

        if (emit) begin
            o_next = '0;
        end else begin
            o_next.counts = counts_n;
            o_next.votes  = votes_n;
            o_next.ticks  = ticks_n;
        end
    end

endmodule

// File: hdl/mode_vote_with_early_stop_core.sv
// ----------------------------------------------------------------------------
// mode_vote_with_early_stop_core
// Majority vote over answers 1..4 with early stop on mode dominance.
// ----------------------------------------------------------------------------
// Input stream: s_tuser selects the kind (0 vote, 1 tick), s_tdata[2:0]
// carries the answer. A vote outside 1..4 is dropped silently.
// Output stream: one report per finished run, ended by early convergence,
// by reaching max_votes or by the tick count reaching timeout_ticks.
// Config channel: i_cfg_index selects the register (0 min_votes,
// 1 max_votes, 2 dominance_percent, 3 timeout_ticks); o_cfg_ready is
// always high. Write only while no report is pending.
// Throughput: one transaction per cycle while s_tready is high. Counters, the
// four-way argmax and the threshold compare are evaluated combinationally
// against the run state; the closing transaction's report is registered in
// the output register, or in the skid entry while the receiver stalls.
// Stall: the output register is backed by one skid entry; s_tready drops
// only while both hold a report, so a stalled receiver costs at most one
// further accepted report before the input side stops.
// Reset: registers return to their defaults and the run state clears.
// ----------------------------------------------------------------------------
module mode_vote_with_early_stop_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [mvote_pkg::S_DATA_W-1:0]      s_tdata,  // [2:0] answer, [7:3] zero
    input  logic                                s_tuser,  // [0] func
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] valid_res, [3:1] mode_value, [11:4] mode_count, [19:12] vote_count,
    // [21:20] end_cause, [23:22] zero
    output logic [mvote_pkg::M_DATA_W-1:0]      m_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mvote_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mvote_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import mvote_pkg::*;

    t_cfg    r_cfg;
    t_run    r_run;
    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;

    t_run    n_run;
    logic    emit;
    t_result res;
    logic    accept;

    assign s_tready    = !r_skid_valid;
    assign accept      = s_tvalid && s_tready;
    assign o_cfg_ready = 1'b1;

    mvote_eval u_eval (
        .i_cfg    (r_cfg),
        .i_run    (r_run),
        .i_tick   (s_tuser),
        .i_answer (s_tdata[2:0]),
        .o_next   (n_run),
        .o_emit   (emit),
        .o_res    (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_votes         <= RST_MIN_VOTES;
            r_cfg.max_votes         <= RST_MAX_VOTES;
            r_cfg.dominance_percent <= RST_DOM_PERCENT;
            r_cfg.timeout_ticks     <= RST_TIMEOUT;
            r_run                   <= '0;
            r_out_valid             <= 1'b0;
            r_out                   <= '0;
            r_skid_valid            <= 1'b0;
            r_skid                  <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_MIN_VOTES:   r_cfg.min_votes         <= i_cfg_data[CNT_W-1:0];
                    REG_MAX_VOTES:   r_cfg.max_votes         <= i_cfg_data[CNT_W-1:0];
                    REG_DOM_PERCENT: r_cfg.dominance_percent <= i_cfg_data[PCT_W-1:0];
                    REG_TIMEOUT:     r_cfg.timeout_ticks     <= i_cfg_data[TICK_W-1:0];
                    default: ;
                endcase
            end

            if (accept) begin
                r_run <= n_run;
            end

            // accept implies the skid entry is free
            if (accept && emit) begin
                if (r_out_valid && !m_tready) begin
                    r_skid       <= res;
                    r_skid_valid <= 1'b1;
                end else begin
                    r_out       <= res;
                    r_out_valid <= 1'b1;
                end
            end else if (r_out_valid && m_tready) begin
                // drain: move skid into the output register, or clear the output valid if the skid is empty
                if (r_skid_valid) begin
                    r_out        <= r_skid;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {2'b00, r_out.end_cause, r_out.vote_count, r_out.mode_count,
                       r_out.mode_value, r_out.valid_res};

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the mode vote core with early stop.
// ----------------------------------------------------------------------------
// Votes, ticks and dropped answers go in on the slave stream. A class-based
// predictor mirrors the run counters and the four registers and queues one
// report per closed run. Each report taken from the master stream is checked
// field by field against the oldest queued report. The run starts with
// short directed runs. Random phases follow, each under its own register
// setting, with bursts of idle cycles on both streams in all but phases 5 and 9.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mvote_pkg::*;

    localparam logic FUNC_VOTE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    localparam int unsigned NUM_PHASES  = 10;
    localparam int unsigned PHASE_ITEMS = 160;
    localparam int unsigned CYCLE_LIMIT = 200000;

    class mode_predictor;
        t_cfg              cfg;
        t_counts           counts;
        logic [CNT_W-1:0]  votes;
        logic [TICK_W-1:0] ticks;
        t_result           expected_reports[$];
        int unsigned       errors;

        function new();
            cfg.min_votes         = RST_MIN_VOTES;
            cfg.max_votes         = RST_MAX_VOTES;
            cfg.dominance_percent = RST_DOM_PERCENT;
            cfg.timeout_ticks     = RST_TIMEOUT;
            errors                = 0;
            clear_run();
        endfunction

        function void clear_run();
            counts = '0;
            votes  = '0;
            ticks  = '0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_MIN_VOTES:   cfg.min_votes         = data[CNT_W-1:0];
                REG_MAX_VOTES:   cfg.max_votes         = data[CNT_W-1:0];
                REG_DOM_PERCENT: cfg.dominance_percent = data[PCT_W-1:0];
                REG_TIMEOUT:     cfg.timeout_ticks     = data[TICK_W-1:0];
                default: ;
            endcase
        endfunction

        // strict compare while scanning upward, so a tie goes to the smaller answer
        function void find_mode(output logic [ANS_W-1:0] val, output logic [CNT_W-1:0] cnt);
            val = '0;
            cnt = '0;
            for (int a = 0; a < NUM_ANSWERS; a++) begin
                if (counts[a] > cnt) begin
                    cnt = counts[a];
                    val = ANS_W'(a + 1);
                end
            end
        endfunction

        function void close_run(logic [1:0] cause);
            t_result r;
            find_mode(r.mode_value, r.mode_count);
            r.valid_res  = (votes >= cfg.min_votes);
            r.vote_count = votes;
            r.end_cause  = cause;
            expected_reports = {expected_reports, r};
            clear_run();
        endfunction

        function void take_item(logic func, logic [ANS_W-1:0] ans);
            logic [ANS_W-1:0] val;
            logic [CNT_W-1:0] cnt;
            logic [1:0]       idx;
            if (func == FUNC_TICK) begin
                if (ticks != '1)
                    ticks = ticks + 1'b1;
                if (ticks >= cfg.timeout_ticks)
                    close_run(CAUSE_TIMEOUT);
                return;
            end
            if (ans < 1 || ans > NUM_ANSWERS)
                return;
            idx         = 2'(ans - 3'd1);
            counts[idx] = counts[idx] + 1'b1;
            votes       = votes + 1'b1;
            if (votes >= cfg.min_votes) begin
                find_mode(val, cnt);
                if (int'(cnt) * 100 > int'(cfg.dominance_percent) * int'(votes)) begin
                    close_run(CAUSE_EARLY);
                    return;
                end
            end
            if (votes >= cfg.max_votes)
                close_run(CAUSE_MAX);
        endfunction

        function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
            if (exp_v != act_v) begin
                $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_report(logic [M_DATA_W-1:0] d);
            t_result got;
            t_result exp_r;
            got.valid_res  = d[0];
            got.mode_value = d[3:1];
            got.mode_count = d[11:4];
            got.vote_count = d[19:12];
            got.end_cause  = d[21:20];
            if (expected_reports.size() == 0) begin
                $error("report with nothing pending: tdata %h", d);
                errors++;
                return;
            end
            exp_r = expected_reports.pop_front();
            compare_field("valid_res", exp_r.valid_res, got.valid_res);
            compare_field("mode_value", exp_r.mode_value, got.mode_value);
            compare_field("mode_count", exp_r.mode_count, got.mode_count);
            compare_field("vote_count", exp_r.vote_count, got.vote_count);
            compare_field("end_cause", exp_r.end_cause, got.end_cause);
        endfunction

        function int unsigned pending();
            return expected_reports.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;   // [2:0] answer, [7:3] zero
    logic                  s_tuser;   // [0] func
    logic                  m_tvalid;
    logic                  m_tready;
    // [0] valid_res, [3:1] mode_value, [11:4] mode_count, [19:12] vote_count,
    // [21:20] end_cause, [23:22] zero
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    mode_predictor votes_pred;
    logic          idle_en = 1'b1;
    int unsigned   stall_left = 0;
    int unsigned   cycles = 0;

    mode_vote_with_early_stop_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4ns i_clk = 1'b1;
        #4ns i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // report check and receiver stalls
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready)
            votes_pred.check_report(m_tdata);
        if (stall_left == 0 && idle_en && $urandom_range(0, 4) == 0)
            stall_left = $urandom_range(1, 3);
        if (stall_left != 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_item(input logic func, input logic [ANS_W-1:0] ans);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {{(S_DATA_W - ANS_W){1'b0}}, ans};
        do @(posedge i_clk); while (!s_tready);
        votes_pred.take_item(func, ans);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        votes_pred.set_reg(idx, data);
    endtask

    // block must be idle here; valid stays high across the four transactions
    task automatic write_config(input int unsigned min_v, input int unsigned max_v,
                                input int unsigned pct, input int unsigned tout);
        write_reg(REG_MIN_VOTES, CFG_DATA_W'(min_v));
        write_reg(REG_MAX_VOTES, CFG_DATA_W'(max_v));
        write_reg(REG_DOM_PERCENT, CFG_DATA_W'(pct));
        write_reg(REG_TIMEOUT, CFG_DATA_W'(tout));
        i_cfg_valid <= 1'b0;
    endtask

    // drop valid, drain pending reports, then let the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (votes_pred.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        int unsigned      min_v, max_v, pct, tout, tick_pct, r;
        logic [ANS_W-1:0] fav, ans;
        votes_pred  = new();
        i_rst_n     <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= FUNC_VOTE;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // timeout with no votes, dropped answers, tie on timeout, tie at max_votes
        write_config(2, 4, 100, 0);
        send_item(FUNC_TICK, 3'd0);
        send_item(FUNC_VOTE, 3'd0);
        send_item(FUNC_VOTE, 3'd5);
        send_item(FUNC_VOTE, 3'd6);
        send_item(FUNC_VOTE, 3'd7);
        send_item(FUNC_VOTE, 3'd2);
        send_item(FUNC_VOTE, 3'd1);
        send_item(FUNC_TICK, 3'd7);
        send_item(FUNC_VOTE, 3'd4);
        send_item(FUNC_VOTE, 3'd4);
        send_item(FUNC_VOTE, 3'd3);
        send_item(FUNC_VOTE, 3'd3);
        drain();

        // no minimum and zero percent: every vote stops early
        write_config(0, 0, 0, 65535);
        send_item(FUNC_VOTE, 3'd4);
        send_item(FUNC_VOTE, 3'd1);
        drain();

        // early stop impossible, zero max_votes ends on the first vote
        write_config(0, 0, 127, 1);
        send_item(FUNC_VOTE, 3'd2);
        send_item(FUNC_TICK, 3'd0);
        send_item(FUNC_VOTE, 3'd3);
        send_item(FUNC_TICK, 3'd5);
        drain();

        // share exactly above the threshold: 300 > 99 * 3
        write_config(3, 255, 99, 65535);
        send_item(FUNC_VOTE, 3'd1);
        send_item(FUNC_VOTE, 3'd1);
        send_item(FUNC_VOTE, 3'd1);
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin min_v = 0;   max_v = 1;   pct = 0;   tout = 1;     tick_pct = 20; end
                1: begin min_v = 255; max_v = 255; pct = 100; tout = 65535; tick_pct = 5;  end
                2: begin min_v = 5;   max_v = 30;  pct = 50;  tout = 20;    tick_pct = 10; end
                3: begin min_v = 10;  max_v = 60;  pct = 70;  tout = 100;   tick_pct = 5;  end
                4: begin min_v = 1;   max_v = 8;   pct = 127; tout = 6;     tick_pct = 15; end
                5: begin min_v = 20;  max_v = 100; pct = 30;  tout = 50;    tick_pct = 3;  end
                default: begin
                    min_v    = $urandom_range(0, 40);
                    max_v    = $urandom_range(1, 80);
                    pct      = $urandom_range(0, 127);
                    tout     = $urandom_range(1, 200);
                    tick_pct = $urandom_range(2, 20);
                end
            endcase
            idle_en = (p != 5 && p != NUM_PHASES - 1);
            fav     = ANS_W'($urandom_range(1, 4));
            write_config(min_v, max_v, pct, tout);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                r = $urandom_range(0, 99);
                if (r < tick_pct) begin
                    ans = ANS_W'($urandom_range(0, 7));
                    send_item(FUNC_TICK, ans);
                end else if (r < tick_pct + 4) begin
                    // answers outside 1..4 are dropped by the block
                    ans = ANS_W'($urandom_range(5, 8));
                    send_item(FUNC_VOTE, ans);
                end else if ($urandom_range(0, 1) == 0) begin
                    send_item(FUNC_VOTE, fav);
                end else begin
                    ans = ANS_W'($urandom_range(1, 4));
                    send_item(FUNC_VOTE, ans);
                end
            end
            drain();
        end

        repeat (10) @(posedge i_clk);
        if (votes_pred.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
